// ----- rtl/core/vlpm_pkg.sv -----
// ----------------------------------------------------------------------------
// vlpm_pkg
// Shared types, widths and saturation helpers for the voice level/pan mixer.
// ----------------------------------------------------------------------------
package vlpm_pkg;

    localparam int SAMPLE_W = 16;
    localparam int ENV_W    = 10;
    localparam int TL_W     = 8;
    localparam int DLVL_W   = 3;
    localparam int PAN_W    = 5;
    localparam int ACC_W    = 22;
    localparam int GAIN_W   = 15;
    localparam int ATT_W    = 17;
    localparam int ADD_W    = 20;
    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 32;

    typedef struct packed {
        logic capture;
        logic mul;
        logic gain;
        logic acc;
    } vlpm_cmd_t;

    typedef struct packed {
        logic item_last;
        logic out_full;
    } vlpm_stat_t;

    function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [ACC_W:0] v);
        logic signed [ACC_W-1:0] r;
        if (v[ACC_W] != v[ACC_W-1]) begin
            r = v[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end else begin
            r = v[ACC_W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [ACC_W-1:0] v);
        logic signed [SAMPLE_W-1:0] r;
        if (v > $signed(22'sd32767)) begin
            r = 16'sh7FFF;
        end else if (v < -$signed(22'sd32768)) begin
            r = 16'sh8000;
        end else begin
            r = v[SAMPLE_W-1:0];
        end
        return r;
    endfunction

endpackage

// ----- rtl/core/vlpm_ctrl.sv -----
// ----------------------------------------------------------------------------
// vlpm_ctrl
// Sequencer: capture, attenuate, apply gains, accumulate and hand off.
// ----------------------------------------------------------------------------
module vlpm_ctrl
    import vlpm_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic       m_tready,
    input  vlpm_stat_t stat,
    output vlpm_cmd_t  cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_GAIN = 2'd2;
    localparam logic [1:0] ST_ACC  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       finish_ok;

    // a frame-end result may not overwrite one still waiting
    assign finish_ok = !stat.item_last || !stat.out_full || m_tready;

    always_comb begin
        s_tready    = (state_reg == ST_IDLE) || ((state_reg == ST_ACC) && finish_ok);
        cmd.capture = s_tvalid && s_tready;
        cmd.mul     = (state_reg == ST_MUL);
        cmd.gain    = (state_reg == ST_GAIN);
        cmd.acc     = (state_reg == ST_ACC) && finish_ok;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (cmd.capture) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:  state_next = ST_GAIN;
            ST_GAIN: state_next = ST_ACC;
            ST_ACC: begin
                if (finish_ok) begin
                    state_next = cmd.capture ? ST_MUL : ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- rtl/core/vlpm_datapath.sv -----
// ----------------------------------------------------------------------------
// vlpm_datapath
// Log attenuation, pan gains, saturating accumulators and output register.
// ----------------------------------------------------------------------------
module vlpm_datapath
    import vlpm_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  vlpm_cmd_t           cmd,
    output vlpm_stat_t          stat,
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic                s_tlast,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata
);

    // captured beat
    logic signed [SAMPLE_W-1:0] smp_reg;
    logic [ENV_W-1:0]           env_reg;
    logic [TL_W-1:0]            tl_reg;
    logic [DLVL_W-1:0]          dlvl_reg;
    logic [PAN_W-1:0]           pan_reg;
    logic                       last_reg;

    // attenuation stage
    logic signed [23:0]         prod_reg;
    logic [3:0]                 exp_reg;
    logic [GAIN_W-1:0]          gl_reg;
    logic [GAIN_W-1:0]          gr_reg;

    // gain stage
    logic signed [ADD_W-1:0]    addl_reg;
    logic signed [ADD_W-1:0]    addr_reg;

    logic signed [ACC_W-1:0]    lsum_reg;
    logic signed [ACC_W-1:0]    lsum_next;
    logic signed [ACC_W-1:0]    rsum_reg;
    logic signed [ACC_W-1:0]    rsum_next;
    logic                       ovalid_reg;
    logic                       ovalid_next;
    logic signed [SAMPLE_W-1:0] lout_reg;
    logic signed [SAMPLE_W-1:0] rout_reg;

    logic [ENV_W:0]             lvl_sum;
    logic [ENV_W-1:0]           level;
    logic [6:0]                 mant;
    logic [GAIN_W-1:0]          base;
    logic [GAIN_W-1:0]          panv;
    logic [GAIN_W-1:0]          gl;
    logic [GAIN_W-1:0]          gr;
    logic [4:0]                 shamt;
    logic signed [23:0]         att_full;
    logic signed [ATT_W-1:0]    att;
    logic signed [33:0]         pl;
    logic signed [33:0]         pr;
    logic signed [ACC_W:0]      lsum_wide;
    logic signed [ACC_W:0]      rsum_wide;
    logic signed [ACC_W-1:0]    lsum_sat;
    logic signed [ACC_W-1:0]    rsum_sat;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            smp_reg  <= s_tdata[15:0];
            env_reg  <= s_tdata[25:16];
            tl_reg   <= s_tdata[33:26];
            dlvl_reg <= s_tdata[36:34];
            pan_reg  <= s_tdata[41:37];
            last_reg <= s_tlast;
        end
    end

    // level, mantissa and pan gains
    always_comb begin
        lvl_sum = {1'b0, env_reg} + {1'b0, tl_reg, 2'b00};
        level   = lvl_sum[ENV_W] ? {ENV_W{1'b1}} : lvl_sum[ENV_W-1:0];
        mant    = {1'b1, ~level[5:0]};
        base    = GAIN_W'(15'h80 << dlvl_reg);
        panv    = base >> pan_reg[3:1];
        if (pan_reg[0]) begin
            panv = panv - (panv >> 2);
        end
        if (pan_reg[3:0] == 4'hF) begin
            panv = '0;
        end
        if (dlvl_reg == '0) begin
            gl = '0;
            gr = '0;
        end else if (pan_reg[4]) begin
            gl = base;
            gr = panv;
        end else begin
            gl = panv;
            gr = base;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.mul) begin
            prod_reg <= smp_reg * $signed({1'b0, mant});
            exp_reg  <= level[9:6];
            gl_reg   <= gl;
            gr_reg   <= gr;
        end
    end

    always_comb begin
        shamt    = {1'b0, exp_reg} + 5'd7;
        att_full = prod_reg >>> shamt;
        att      = att_full[ATT_W-1:0];
        pl       = att * $signed({2'b00, gl_reg});
        pr       = att * $signed({2'b00, gr_reg});
    end

    always_ff @(posedge aclk) begin
        if (cmd.gain) begin
            addl_reg <= pl[33:14];
            addr_reg <= pr[33:14];
        end
    end

    always_comb begin
        lsum_wide   = {lsum_reg[ACC_W-1], lsum_reg}
                      + {{(ACC_W+1-ADD_W){addl_reg[ADD_W-1]}}, addl_reg};
        rsum_wide   = {rsum_reg[ACC_W-1], rsum_reg}
                      + {{(ACC_W+1-ADD_W){addr_reg[ADD_W-1]}}, addr_reg};
        lsum_sat    = sat_acc(lsum_wide);
        rsum_sat    = sat_acc(rsum_wide);
        lsum_next   = lsum_reg;
        rsum_next   = rsum_reg;
        ovalid_next = ovalid_reg && !m_tready;
        if (cmd.acc) begin
            if (last_reg) begin
                lsum_next   = '0;
                rsum_next   = '0;
                ovalid_next = 1'b1;
            end else begin
                lsum_next = lsum_sat;
                rsum_next = rsum_sat;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lsum_reg   <= '0;
            rsum_reg   <= '0;
            ovalid_reg <= 1'b0;
        end else begin
            lsum_reg   <= lsum_next;
            rsum_reg   <= rsum_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.acc && last_reg) begin
            lout_reg <= sat16(lsum_sat);
            rout_reg <= sat16(rsum_sat);
        end
    end

    assign stat.item_last = last_reg;
    assign stat.out_full  = ovalid_reg;
    assign m_tvalid       = ovalid_reg;
    assign m_tdata        = {rout_reg, lout_reg};

endmodule

// ----- rtl/core/voice_level_pan_mixer_unit.sv -----
// ----------------------------------------------------------------------------
// voice_level_pan_mixer_unit
// Per-voice log attenuation and pan, stereo frame accumulation and output.
// ----------------------------------------------------------------------------
// Output: a frame-end beat raises m_tvalid after the multiply, gain and accumulate states.
// Input: each beat passes capture, attenuate multiply and gain multiplies before
//   the next is taken; the accumulate step overlaps the next capture.
// A waiting result stalls input only when the next frame end is reached.
// Reset (synchronous, aresetn low) clears the sequencer, sums and m_tvalid.
module voice_level_pan_mixer_unit
    import vlpm_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    // sample[15:0], env_level[25:16], total_level[33:26],
    // direct_level[36:34], direct_pan[41:37], zero pad [47:42]
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic                s_tlast,
    output logic                m_tvalid,
    input  logic                m_tready,
    // left_out[15:0], right_out[31:16]
    output logic [M_DATA_W-1:0] m_tdata
);

    vlpm_cmd_t  cmd;
    vlpm_stat_t stat;

    vlpm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    vlpm_datapath u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ----- rtl/core/vlpm_checker.sv -----
// ----------------------------------------------------------------------------
// vlpm_checker
// Port-level checks on the mixer's stream handshakes and sequencing.
// ----------------------------------------------------------------------------
module vlpm_checker
    import vlpm_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic                s_tlast,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken on consecutive cycles");

    a_result_from_last: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tlast, 4))
        else $error("result without a frame-end beat");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("m_tvalid set after reset");

endmodule

bind voice_level_pan_mixer_unit vlpm_checker u_vlpm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
